@@ src/sdpm_pkg.sv @@
package sdpm_pkg;

   // Query store geometry and term key width
   localparam int QUERY_DEPTH = 64;
   localparam int TERM_BITS   = 20;
   localparam int ADDR_BITS   = $clog2(QUERY_DEPTH);
   localparam int LEN_BITS    = $clog2(QUERY_DEPTH + 1);

   // Port field widths
   localparam int REQ_TERM_BITS = 20;
   localparam int WEIGHT_BITS   = 16;
   localparam int PROD_BITS     = 2 * WEIGHT_BITS;
   localparam int SCORE_BITS    = 48;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DOC  = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [TERM_BITS-1:0]   term;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   last;
   } item_type;

   // Queue head handshake toward the back part
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Key used by the merge: low TERM_BITS bits of the term, zero extended
   function automatic logic [TERM_BITS-1:0] term_key(input logic [REQ_TERM_BITS-1:0] t);
      logic [31:0] wide;
      wide = 32'(t);
      return wide[TERM_BITS-1:0];
   endfunction

endpackage

@@ src/sparse_dot_product_merge.sv @@
// Channel   Handshake          Payload
// req       push / full        req_operation, req_term, req_weight, req_last
// rsp       pop / empty        rsp_score, rsp_saturated
//
// A four-item queue takes one item per cycle while it has room.
// The merge engine stores a query element in its idle step. A document
// element takes a fetch and a compare step per stored query entry read (one
// read of the query store per entry), an accumulate step on a term match,
// and a done step; a fetch past the query's end skips to the done step.
// Reset is synchronous; the query store is not cleared and needs no pass.
// A waiting result stalls only the engine's final step of a last element.
module sparse_dot_product_merge
   import sdpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_operation,
   input  logic [REQ_TERM_BITS-1:0] req_term,
   input  logic [WEIGHT_BITS-1:0]   req_weight,
   input  logic                     req_last,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [SCORE_BITS-1:0]    rsp_score,
   output logic                     rsp_saturated
);

   head_type head;
   logic     head_pop;

   sdpm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_term      (req_term),
      .req_weight    (req_weight),
      .req_last      (req_last),
      .head          (head),
      .head_pop      (head_pop)
   );

   sdpm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_pop      (head_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_score     (rsp_score),
      .rsp_saturated (rsp_saturated)
   );

endmodule

@@ src/sdpm_front.sv @@
module sdpm_front
   import sdpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_operation,
   input  logic [REQ_TERM_BITS-1:0] req_term,
   input  logic [WEIGHT_BITS-1:0]   req_weight,
   input  logic                     req_last,
   output head_type                 head,
   input  logic                     head_pop
);

   item_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push_ok;
   logic                 pop_ok;
   item_type             new_item;

   // Classify and normalize the incoming item
   always_comb begin
      new_item.operation = req_operation;
      new_item.term      = term_key(req_term);
      new_item.weight    = req_weight;
      new_item.last      = req_last;
   end

   assign req_full   = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = head_pop && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ src/sdpm_back.sv @@
module sdpm_back
   import sdpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  head_type               head,
   output logic                   head_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [SCORE_BITS-1:0]  rsp_score,
   output logic                   rsp_saturated
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // Query store
   logic [TERM_BITS-1:0]   term_mem   [QUERY_DEPTH];
   logic [WEIGHT_BITS-1:0] weight_mem [QUERY_DEPTH];

   logic [2:0]             state_ff, state_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [LEN_BITS-1:0]    load_pos_ff, load_pos_in;
   logic [LEN_BITS-1:0]    ptr_ff, ptr_in;
   logic [SCORE_BITS-1:0]  acc_ff, acc_in;
   logic                   sat_ff, sat_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SCORE_BITS-1:0]  out_score_ff;
   logic                   out_sat_ff;
   logic [TERM_BITS-1:0]   doc_term_ff;
   logic [WEIGHT_BITS-1:0] doc_weight_ff;
   logic                   doc_last_ff;
   logic [TERM_BITS-1:0]   rd_term_ff;
   logic [WEIGHT_BITS-1:0] rd_weight_ff;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;

   logic                   mem_we;
   logic                   mem_re;
   logic                   doc_take;
   logic                   emit;
   logic                   slot_free;
   logic [SCORE_BITS:0]    sum;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign sum       = {1'b0, acc_ff} + (SCORE_BITS + 1)'(prod_ff);

   // Merge sequencer
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      load_pos_in = load_pos_ff;
      ptr_in      = ptr_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      prod_in     = prod_ff;
      head_pop    = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      doc_take    = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               if (head.item.operation == OP_LOAD) begin
                  // store one query element, drop it when the store is full
                  if (load_pos_ff < LEN_BITS'(QUERY_DEPTH)) begin
                     mem_we      = 1'b1;
                     load_pos_in = load_pos_ff + 1'b1;
                  end
                  if (head.item.last) begin
                     len_in      = load_pos_in;
                     load_pos_in = '0;
                     ptr_in      = '0;
                     acc_in      = '0;
                     sat_in      = 1'b0;
                  end
               end else begin
                  doc_take = 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (ptr_ff < len_ff) begin
               mem_re   = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (rd_term_ff < doc_term_ff) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_FETCH;
            end else if (rd_term_ff == doc_term_ff) begin
               prod_in  = PROD_BITS'(rd_weight_ff) * PROD_BITS'(doc_weight_ff);
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_ACC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACC: begin
            // saturating accumulate
            if (sum[SCORE_BITS]) begin
               acc_in = SCORE_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = sum[SCORE_BITS-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!doc_last_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               emit     = 1'b1;
               ptr_in   = '0;
               acc_in   = '0;
               sat_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result slot
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         load_pos_ff  <= '0;
         ptr_ff       <= '0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         load_pos_ff  <= load_pos_in;
         ptr_ff       <= ptr_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (doc_take) begin
         doc_term_ff   <= head.item.term;
         doc_weight_ff <= head.item.weight;
         doc_last_ff   <= head.item.last;
      end
      if (emit) begin
         out_score_ff <= acc_ff;
         out_sat_ff   <= sat_ff;
      end
   end

   // Query store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         term_mem[load_pos_ff[ADDR_BITS-1:0]]   <= head.item.term;
         weight_mem[load_pos_ff[ADDR_BITS-1:0]] <= head.item.weight;
      end
      if (mem_re) begin
         rd_term_ff   <= term_mem[ptr_ff[ADDR_BITS-1:0]];
         rd_weight_ff <= weight_mem[ptr_ff[ADDR_BITS-1:0]];
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_score     = out_score_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

@@ src/sdpm_checker.sv @@
module sdpm_checker
   import sdpm_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic [SCORE_BITS-1:0]    rsp_score,
   input logic                     rsp_saturated
);

   // Reset leaves no result and an open queue
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or full flag present after reset");

   // A saturated score is pinned at the maximum
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_saturated |-> rsp_score == SCORE_MAX)
      else $error("saturated result without maximum score");

   // A waiting result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result withdrawn before pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_score) && $stable(rsp_saturated))
      else $error("result changed while waiting");

endmodule

bind sparse_dot_product_merge sdpm_checker u_checker (.*);
